@@ rtl/core/afr_pkg.sv @@
// ---------------------------------------------------------------------------
// afr_pkg
// Shared types and codes for the API frame receiver: word layouts, register
// indexes, frame status codes and the frame type codes it decodes.
// ---------------------------------------------------------------------------
package afr_pkg;

  localparam int MAX_FRAME_DEF = 128;
  localparam int CHANNELS      = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFCH = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SMALL  = 3'd1;
  localparam logic [2:0] ST_CKSUM  = 3'd2;
  localparam logic [2:0] ST_LARGE  = 3'd3;
  localparam logic [2:0] ST_SUBHDR = 3'd4;

  localparam logic [7:0] TY_MODEM  = 8'h8A;
  localparam logic [7:0] TY_RECV   = 8'h90;
  localparam logic [7:0] TY_EXRECV = 8'h91;
  localparam logic [7:0] TY_ATR    = 8'h88;
  localparam logic [7:0] TY_RATR   = 8'h97;
  localparam logic [7:0] TY_XSTAT  = 8'h8B;
  localparam logic [7:0] TY_NODE   = 8'h95;

  localparam logic [7:0] CKSUM_GOOD = 8'hFF;
  localparam logic [2:0] HDR_SHORT  = 3'd4;
  localparam logic [2:0] HDR_LONG   = 3'd5;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] frame_status;
    logic [7:0] frame_type;
    logic [3:0] dest_channel;
    logic [6:0] payload_length;
    logic       response_error;
    logic       unknown_type;
    logic [7:0] retry_count;
    logic [7:0] read_data;
  } out_word_t;

  // header bytes of the frame being completed, with the last byte forwarded
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] ftype;
    logic [7:0] id;
    logic [7:0] b7;
    logic [7:0] b8;
    logic [7:0] b17;
  } frm_info_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] chan;
    logic [6:0] plen;
    logic       err;
    logic       unk;
    logic [7:0] retry;
    logic [2:0] hdr_len;
  } frm_sum_t;

endpackage

@@ rtl/core/api_frame_receiver.sv @@
// ---------------------------------------------------------------------------
// api_frame_receiver
// Byte-serial parser for delimited, length-prefixed, checksummed API frames.
// ---------------------------------------------------------------------------
// Takes one word per cycle unless the output is stalled, serial byte or
// payload read alike, with no gaps. The frame store is a RAM with a
// registered read port, so each word passes one stage that waits for the read
// data and then the output register. Frame bytes are written to the store as
// they arrive; the header bytes needed for the final checks are also kept in
// registers, so a frame is judged on the cycle its last byte arrives. Payload
// reads see every byte written by earlier words.
// ---------------------------------------------------------------------------
module api_frame_receiver #(
  parameter int MAX_FRAME = afr_pkg::MAX_FRAME_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  afr_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output afr_pkg::out_word_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [afr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int FW = $clog2(MAX_FRAME + 1);

  // configuration
  logic [7:0]  delim_r;
  logic [15:0] mask_r;
  logic [3:0]  defch_r;

  // receive state
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    exp_r, exp_nxt;
  logic [2:0]    hdr_r, hdr_nxt;
  logic [7:0]    b1_r, b2_r, b3_r, b4_r, b7_r, b8_r, b17_r;

  // result pipeline
  logic               s1_valid_r, s1_valid_nxt;
  afr_pkg::out_word_t s1_word_r, s1_word_nxt;
  logic               s1_rzero_r;
  logic               out_valid_r, out_valid_nxt;
  afr_pkg::out_word_t out_word_r, out_word_nxt;

  logic          s1_adv, in_acc, rx, rd, overfull, store;
  logic [7:0]    b;
  logic [FW-1:0] fill_inc;
  logic [16:0]   exp_full;
  logic          too_big, at5, past5, finish, reject_big;
  logic [7:0]    rd_idx;
  logic          rd_oob;
  logic [7:0]    ram_rdata;

  afr_pkg::frm_info_t info;
  afr_pkg::frm_sum_t  cls;

  assign cfg_ready = 1'b1;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign rx       = in_acc && !in_data.func;
  assign rd       = in_acc && in_data.func;
  assign b        = in_data.rx_byte;

  assign overfull = fill_r >= FW'(MAX_FRAME);
  assign store    = rx && !overfull && ((fill_r != '0) || (b == delim_r));
  assign fill_inc = fill_r + FW'(1);

  assign exp_full = {1'b0, b1_r, b2_r} + 17'd4;
  assign too_big  = exp_full >= 17'(MAX_FRAME);
  assign at5      = fill_r == FW'(4);
  assign past5    = fill_r > FW'(4);

  // frame ends on the fifth byte at the earliest
  assign finish     = store && ((at5 && !too_big && (exp_full <= 17'd5)) ||
                                (past5 && (8'(fill_inc) >= exp_r)));
  assign reject_big = store && at5 && too_big;

  assign rd_idx = 8'(hdr_r) + 8'(in_data.read_index);
  assign rd_oob = rd_idx >= 8'(MAX_FRAME);

  // last byte of the frame may itself be one of the checked bytes
  always_comb begin
    info.len   = 8'(fill_inc);
    info.sum   = sum_nxt;
    info.ftype = b3_r;
    info.id    = at5 ? b : b4_r;
    info.b7    = (fill_r == FW'(7))  ? b : b7_r;
    info.b8    = (fill_r == FW'(8))  ? b : b8_r;
    info.b17   = (fill_r == FW'(17)) ? b : b17_r;
  end

  afr_classify u_classify (
    .info     (info),
    .reg_mask (mask_r),
    .def_chan (defch_r),
    .res      (cls)
  );

  afr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk   (clk),
    .we    (store),
    .waddr (fill_r[AW-1:0]),
    .wdata (b),
    .re    (rd),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    exp_nxt  = exp_r;
    hdr_nxt  = hdr_r;
    if (rx) begin
      if (overfull) begin
        fill_nxt = '0;
      end else if (store) begin
        fill_nxt = (finish || reject_big) ? '0 : fill_inc;
      end
    end
    if (store) begin
      if (fill_r == '0) begin
        sum_nxt = 8'd0;
      end else if (fill_r >= FW'(3)) begin
        sum_nxt = sum_r + b;
      end
    end
    if (store && at5) begin
      exp_nxt = exp_full[7:0];
    end
    if (finish) begin
      hdr_nxt = cls.hdr_len;
    end
  end

  always_comb begin
    s1_word_nxt = '0;
    if (rd) begin
      s1_word_nxt.result_kind = 1'b1;
    end else if (reject_big) begin
      s1_word_nxt.frame_status = afr_pkg::ST_LARGE;
      s1_word_nxt.frame_type   = b3_r;
    end else begin
      s1_word_nxt.frame_status   = cls.status;
      s1_word_nxt.frame_type     = b3_r;
      s1_word_nxt.dest_channel   = cls.chan;
      s1_word_nxt.payload_length = cls.plen;
      s1_word_nxt.response_error = cls.err;
      s1_word_nxt.unknown_type   = cls.unk;
      s1_word_nxt.retry_count    = cls.retry;
    end

    if (rd || finish || reject_big) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // read data joins the word on its way to the output register
  always_comb begin
    out_word_nxt = s1_word_r;
    if (s1_word_r.result_kind && !s1_rzero_r) begin
      out_word_nxt.read_data = ram_rdata;
    end else begin
      out_word_nxt.read_data = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= 8'h7E;
      mask_r      <= 16'h0001;
      defch_r     <= 4'd0;
      fill_r      <= '0;
      sum_r       <= 8'd0;
      exp_r       <= 8'd0;
      hdr_r       <= afr_pkg::HDR_LONG;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          afr_pkg::CFG_DELIM: delim_r <= cfg_data[7:0];
          afr_pkg::CFG_MASK:  mask_r  <= cfg_data;
          afr_pkg::CFG_DEFCH: defch_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      exp_r       <= exp_nxt;
      hdr_r       <= hdr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // header byte copies and result payload
  always_ff @(posedge clk) begin
    if (store) begin
      unique case (fill_r)
        FW'(1):  b1_r  <= b;
        FW'(2):  b2_r  <= b;
        FW'(3):  b3_r  <= b;
        FW'(4):  b4_r  <= b;
        FW'(7):  b7_r  <= b;
        FW'(8):  b8_r  <= b;
        FW'(17): b17_r <= b;
        default: ;
      endcase
    end
    if (in_acc) begin
      s1_word_r  <= s1_word_nxt;
      s1_rzero_r <= rd_oob;
    end
    if (s1_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

@@ rtl/core/afr_ram.sv @@
// ---------------------------------------------------------------------------
// afr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module afr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/afr_classify.sv @@
// ---------------------------------------------------------------------------
// afr_classify
// Final checks of a completed frame: size, checksum, sub-header length,
// type decode, status/retry extraction and delivery channel fallback.
// ---------------------------------------------------------------------------
module afr_classify (
  input  afr_pkg::frm_info_t info,
  input  logic [15:0]        reg_mask,
  input  logic [3:0]         def_chan,
  output afr_pkg::frm_sum_t  res
);

  logic [2:0] hdr;
  logic [7:0] minlen;
  logic       use_id;
  logic       unk;
  logic       err;
  logic [7:0] retry;
  logic       id_ok;
  logic [7:0] plen_full;

  always_comb begin
    hdr    = afr_pkg::HDR_LONG;
    minlen = 8'd0;
    use_id = 1'b0;
    unk    = 1'b0;
    err    = 1'b0;
    retry  = 8'd0;
    unique case (info.ftype)
      afr_pkg::TY_MODEM, afr_pkg::TY_RECV, afr_pkg::TY_EXRECV: begin
        hdr = afr_pkg::HDR_SHORT;
      end
      afr_pkg::TY_ATR: begin
        minlen = 8'd8;
        use_id = 1'b1;
        err    = info.b7 != 8'd0;
      end
      afr_pkg::TY_RATR: begin
        minlen = 8'd18;
        use_id = 1'b1;
        err    = info.b17 != 8'd0;
      end
      afr_pkg::TY_XSTAT: begin
        minlen = 8'd10;
        use_id = 1'b1;
        retry  = info.b7;
        err    = info.b8 != 8'd0;
      end
      afr_pkg::TY_NODE: begin
        use_id = 1'b1;
      end
      default: begin
        unk = 1'b1;
      end
    endcase

    id_ok     = use_id && (info.id < 8'(afr_pkg::CHANNELS)) && reg_mask[info.id[3:0]];
    plen_full = info.len - 8'(hdr) - 8'd1;

    res         = '0;
    res.hdr_len = hdr;
    priority if (info.len < 8'(hdr) + 8'd1) begin
      res.status = afr_pkg::ST_SMALL;
    end else if (info.sum != afr_pkg::CKSUM_GOOD) begin
      res.status = afr_pkg::ST_CKSUM;
    end else if (info.len < minlen) begin
      res.status = afr_pkg::ST_SUBHDR;
    end else begin
      res.status = afr_pkg::ST_OK;
      res.chan   = id_ok ? info.id[3:0] : def_chan;
      res.plen   = (plen_full > 8'd127) ? 7'd127 : plen_full[6:0];
      res.err    = err;
      res.unk    = unk;
      res.retry  = retry;
    end
  end

endmodule
